[src/adu_pkg.sv]
// Shared constants, types and the tanh table of the activation and derivative unit.
package adu_pkg;

    localparam int DATA_W        = 16;
    localparam int FRAC_BITS     = 12;
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = 8;
    localparam int HI_FRAC       = 30;
    localparam int ROM_W         = 32;
    localparam int T_W           = ROM_W + 1;
    localparam int FRAC_W        = FRAC_BITS + 1 + 4 - IDX_W;
    localparam int PROD_W        = T_W + FRAC_W + 1;
    localparam int SQ_W          = 2 * ROM_W;
    localparam int SUM_W         = 40;
    localparam int SAT_IN_W      = 20;

    localparam logic [63:0] HI_ONE = 64'd1 << HI_FRAC;
    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] MAX_Q = DATA_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [DATA_W-1:0] MIN_Q = DATA_W'(1 << (DATA_W - 1));

    typedef enum logic [1:0] {
        KIND_LINEAR  = 2'd0,
        KIND_RELU    = 2'd1,
        KIND_SIGMOID = 2'd2,
        KIND_TANH    = 2'd3
    } t_kind;

    // Per-item side information that rides along the pipeline.
    typedef struct packed {
        t_kind                     kind;
        logic                      mode;
        logic signed [DATA_W-1:0]  sample;
    } t_meta;

    typedef logic signed [ROM_W-1:0] t_rom [0:TABLE_ENTRIES];

    // Unsigned 64-bit quotient by restoring shift and subtract; used only while
    // the table is built.
    function automatic logic [63:0] udiv_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) for f in [0,1], Q30, by a 25-term Taylor series.
    function automatic logic [63:0] exp_neg_unit(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = HI_ONE;
        sum  = HI_ONE;
        for (int k = 1; k <= 24; k++) begin
            term = udiv_u64((term * f) >> HI_FRAC, 64'(k));
            if ((k & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // exp(-y) for y in [0,16], Q30.
    function automatic logic [63:0] exp_neg(input logic [63:0] y);
        logic [63:0] whole;
        logic [63:0] r;
        logic [63:0] e1;
        whole = y >> HI_FRAC;
        r     = exp_neg_unit(y & (HI_ONE - 64'd1));
        e1    = exp_neg_unit(HI_ONE);
        for (int n = 0; n < 16; n++) begin
            if (64'(n) < whole) begin
                r = (r * e1 + (64'd1 << (HI_FRAC - 1))) >> HI_FRAC;
            end
        end
        return r;
    endfunction

    // Table point i: tanh at -8 + 16*i/TABLE_ENTRIES plus half the chord curvature error.
    function automatic logic signed [ROM_W-1:0] tanh_point(input int i);
        longint      num;
        logic [63:0] mag;
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] c;
        logic [63:0] corr;
        logic [63:0] v;
        num  = 64'(16 * i - 8 * TABLE_ENTRIES);
        mag  = (num < 0) ? 64'(-num) : 64'(num);
        y    = (((2 * mag) << HI_FRAC) + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
        e    = exp_neg(y);
        den  = HI_ONE + e;
        t    = udiv_u64(((HI_ONE - e) << HI_FRAC) + (den >> 1), den);
        t2   = (t * t) >> HI_FRAC;
        c    = (t * (HI_ONE - t2)) >> HI_FRAC;
        corr = (c * 64'd32 + 64'((TABLE_ENTRIES * TABLE_ENTRIES) / 2))
               / 64'(TABLE_ENTRIES * TABLE_ENTRIES);
        v    = t + corr;
        if (num < 0) begin
            v = -v;
        end
        return v[ROM_W-1:0];
    endfunction

    function automatic t_rom build_tanh_rom();
        t_rom rom;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            rom[i] = tanh_point(i);
        end
        return rom;
    endfunction

    localparam t_rom TANH_ROM = build_tanh_rom();

    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_IN_W'(MAX_Q)) begin
            res = MAX_Q;
        end else if (v < SAT_IN_W'(MIN_Q)) begin
            res = MIN_Q;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/adu_interp.sv]
// Table lookup and linear interpolation of tanh: three pipeline stages.
module adu_interp
    import adu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_vld,
    input  t_meta                   i_meta,
    output logic                    o_vld,
    output t_meta                   o_meta,
    output logic signed [T_W-1:0]   o_tanh
);

    logic [DATA_W:0]          w_pos_s;
    logic [IDX_W-1:0]         w_idx;
    logic [FRAC_W-1:0]        w_frac;
    logic signed [T_W-1:0]    w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [PROD_W-1:0] w_step;

    logic                     r_a_vld, r_b_vld, r_c_vld;
    t_meta                    r_a_meta, r_b_meta, r_c_meta;
    logic signed [ROM_W-1:0]  r_a_lo, r_a_hi, r_b_lo;
    logic [FRAC_W-1:0]        r_a_frac;
    logic signed [PROD_W-1:0] r_b_prod;
    logic signed [T_W-1:0]    r_c_t;

    // Sigmoid looks up tanh(x/2): the same table with one more fraction bit.
    always_comb begin
        w_pos_s = {i_meta.sample[DATA_W-1], i_meta.sample} + (DATA_W+1)'(1 << DATA_W);
        if (i_meta.kind == KIND_SIGMOID) begin
            w_idx  = w_pos_s[DATA_W:FRAC_W];
            w_frac = w_pos_s[FRAC_W-1:0];
        end else begin
            w_idx  = {~i_meta.sample[DATA_W-1], i_meta.sample[DATA_W-2:FRAC_W-1]};
            w_frac = {i_meta.sample[FRAC_W-2:0], 1'b0};
        end
    end

    assign w_diff     = T_W'(r_a_hi) - T_W'(r_a_lo);
    assign w_prod     = PROD_W'(w_diff) * PROD_W'(signed'({1'b0, r_a_frac}));
    // Interpolation step is truncated toward zero.
    assign w_prod_rnd = r_b_prod[PROD_W-1] ? (r_b_prod + PROD_W'((1 << FRAC_W) - 1))
                                           : r_b_prod;
    assign w_step     = w_prod_rnd >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_meta <= i_meta;
            r_a_lo   <= TANH_ROM[{1'b0, w_idx}];
            r_a_hi   <= TANH_ROM[{1'b0, w_idx} + (IDX_W+1)'(1)];
            r_a_frac <= w_frac;
            r_b_meta <= r_a_meta;
            r_b_lo   <= r_a_lo;
            r_b_prod <= w_prod;
            r_c_meta <= r_b_meta;
            r_c_t    <= T_W'(r_b_lo) + w_step[T_W-1:0];
        end
    end

    assign o_vld  = r_c_vld;
    assign o_meta = r_c_meta;
    assign o_tanh = r_c_t;

endmodule

[src/adu_finish.sv]
// Activation and derivative forming, result selection and the output register.
module adu_finish
    import adu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_vld,
    input  t_meta                      i_meta,
    input  logic signed [T_W-1:0]      i_tanh,
    output logic                       o_vld,
    output logic signed [DATA_W-1:0]   o_value
);

    localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * HI_FRAC);

    logic [ROM_W-1:0]         w_mag;
    logic signed [SUM_W-1:0]  w_sig_sum, w_tanh_sum;
    logic [SQ_W-1:0]          w_q, w_sig_rnd, w_tanh_rnd;
    logic signed [DATA_W-1:0] w_result;

    logic                     r_d_vld, r_out_vld;
    t_meta                    r_d_meta;
    logic [SQ_W-1:0]          r_d_sq;
    logic signed [DATA_W-1:0] r_d_act;
    logic signed [DATA_W-1:0] r_out_val;

    assign w_mag      = i_tanh[T_W-1] ? ROM_W'(-i_tanh) : i_tanh[ROM_W-1:0];
    assign w_sig_sum  = SUM_W'(i_tanh) + SUM_W'((1 << HI_FRAC) + (1 << (HI_FRAC - FRAC_BITS)));
    assign w_tanh_sum = SUM_W'(i_tanh) + SUM_W'(1 << (HI_FRAC - FRAC_BITS - 1));

    // 1 - t^2 clamped at zero, then scaled and rounded.
    assign w_q        = (SQ_ONE > r_d_sq) ? (SQ_ONE - r_d_sq) : '0;
    assign w_sig_rnd  = (w_q + (SQ_W'(1) << (2 * HI_FRAC + 1 - FRAC_BITS)))
                        >> (2 * HI_FRAC + 2 - FRAC_BITS);
    assign w_tanh_rnd = (w_q + (SQ_W'(1) << (2 * HI_FRAC - 1 - FRAC_BITS)))
                        >> (2 * HI_FRAC - FRAC_BITS);

    always_comb begin
        case (r_d_meta.kind)
            KIND_LINEAR: begin
                w_result = r_d_meta.mode ? ONE_Q : r_d_meta.sample;
            end
            KIND_RELU: begin
                if (r_d_meta.sample > 0) begin
                    w_result = r_d_meta.mode ? ONE_Q : r_d_meta.sample;
                end else begin
                    w_result = '0;
                end
            end
            KIND_SIGMOID: begin
                w_result = r_d_meta.mode ? sat_q(SAT_IN_W'(w_sig_rnd[SAT_IN_W-2:0])) : r_d_act;
            end
            default: begin
                w_result = r_d_meta.mode ? sat_q(SAT_IN_W'(w_tanh_rnd[SAT_IN_W-2:0])) : r_d_act;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_d_vld   <= i_vld;
            r_out_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_meta  <= i_meta;
            r_d_sq    <= SQ_W'(w_mag) * SQ_W'(w_mag);
            r_d_act   <= (i_meta.kind == KIND_SIGMOID)
                         ? sat_q(w_sig_sum[HI_FRAC+1-FRAC_BITS +: SAT_IN_W])
                         : sat_q(w_tanh_sum[HI_FRAC-FRAC_BITS +: SAT_IN_W]);
            r_out_val <= w_result;
        end
    end

    assign o_vld   = r_out_vld;
    assign o_value = r_out_val;

endmodule

[src/activation_and_derivative_unit.sv]
// Top level of the activation and derivative unit: input stage, control and pipeline.
// Stages in order: input, table read, interpolation multiply, accumulate, forming, output.
// Throughput: one beat per cycle; the six-stage pipeline moves as a whole, so a stall
// at the output holds every stage and the input ready follows the output register.
// Reset (synchronous, active low) clears all stage valid bits and sets the activation
// kind to linear; the tanh table is constant logic and needs no initialization.
module activation_and_derivative_unit
    import adu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [DATA_W-1:0]  i_sample_value,
    input  logic                      i_mode,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DATA_W-1:0]  o_result_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_data
);

    // The whole pipeline advances together. It may advance whenever the output
    // register is empty or its beat is being taken this cycle, which is what
    // lets a new beat enter while a finished result is still on the output.
    logic   w_adv;
    t_meta  w_in_meta;

    logic                   r_s0_vld;
    t_meta                  r_s0_meta;
    t_kind                  r_kind;

    logic                   w_int_vld;
    t_meta                  w_int_meta;
    logic signed [T_W-1:0]  w_int_tanh;

    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // The kind is captured with each beat, so every item carries the kind that
    // was in force when it was accepted.
    assign w_in_meta.kind   = r_kind;
    assign w_in_meta.mode   = i_mode;
    assign w_in_meta.sample = i_sample_value;

    // Configuration register. Every two-bit code is a valid kind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_LINEAR;
        end else if (i_cfg_valid) begin
            r_kind <= t_kind'(i_cfg_data);
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_meta <= w_in_meta;
        end
    end

    // Table read, interpolation multiply and accumulate.
    adu_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s0_vld),
        .i_meta  (r_s0_meta),
        .o_vld   (w_int_vld),
        .o_meta  (w_int_meta),
        .o_tanh  (w_int_tanh)
    );

    // Squaring, rounding, selection by kind and mode, and the output register.
    adu_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_int_vld),
        .i_meta  (w_int_meta),
        .i_tanh  (w_int_tanh),
        .o_vld   (o_out_valid),
        .o_value (o_result_value)
    );

    // A stalled output must hold back the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while the output is stalled");

    // A beat held in the input stage during a stall keeps its contents.
    a_input_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_vld && !w_adv) |=> (r_s0_vld && $stable(r_s0_meta)))
        else $error("input stage changed during a stall");

    // Reset returns the kind to linear and empties the input stage and the output.
    a_reset_state: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_kind == KIND_LINEAR && !o_out_valid && !r_s0_vld))
        else $error("state not cleared by reset");

endmodule
